>>> rtl/core/mbrtu_pkg.sv
// mbrtu_pkg: shared constants, codes and types for the modbus rtu register slave
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mbrtu_pkg;
	localparam int RegisterCount = 64;
	localparam int RegAw = (RegisterCount > 1) ? $clog2(RegisterCount) : 1;
	localparam int MaxFrameBytes = 256;
	localparam logic [15:0] CrcSeed = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;
	localparam logic [15:0] ReadLimit = 16'd125;
	localparam logic [7:0] FuncRead = 8'd3;
	localparam logic [7:0] FuncWrite = 8'd6;
	localparam logic [7:0] ExcFunction = 8'd1;
	localparam logic [7:0] ExcAddress = 8'd2;
	localparam logic [7:0] ExcValue = 8'd3;

	// control between sequencer and crc unit
	typedef struct packed {
		logic       init;
		logic       load;
		logic [7:0] data;
	} crc_cmd_t;

	typedef struct packed {
		logic        busy;
		logic [15:0] crc;
	} crc_sts_t;
endpackage
`default_nettype wire

>>> rtl/core/mbrtu_if.sv
// mbrtu_if: valid/ready channel interfaces for request bytes and response groups
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface mbrtu_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;
	modport source (output valid, rx_byte, frame_end, input ready);
	modport sink (input valid, rx_byte, frame_end, output ready);
endinterface

interface mbrtu_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte_0;
	logic [7:0] tx_byte_1;
	logic [7:0] tx_byte_2;
	logic [7:0] tx_byte_3;
	logic [2:0] bytes_valid;
	logic       last_group;
	modport source (output valid, tx_byte_0, tx_byte_1, tx_byte_2, tx_byte_3,
		bytes_valid, last_group, input ready);
	modport sink (input valid, tx_byte_0, tx_byte_1, tx_byte_2, tx_byte_3,
		bytes_valid, last_group, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mbrtu_crc.sv
// mbrtu_crc: bit-serial crc-16 unit, one bit per cycle; a new byte is loaded only while not busy
// depends on mbrtu_pkg
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_crc import mbrtu_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire crc_cmd_t cmd,
	output crc_sts_t      sts
);
	logic [15:0] crc_q;
	logic [3:0]  cnt_q;
	logic [15:0] x;

	assign x = crc_q ^ {8'h00, cmd.data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CrcSeed;
			cnt_q <= '0;
		end else if (cmd.init) begin
			crc_q <= CrcSeed;
			cnt_q <= '0;
		end else if (cmd.load && cnt_q == 4'd0) begin
			crc_q <= x;
			cnt_q <= 4'd8;
		end else if (cnt_q != 4'd0) begin
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CrcPoly) : (crc_q >> 1);
			cnt_q <= cnt_q - 4'd1;
		end
	end

	assign sts.busy = (cnt_q != 4'd0);
	assign sts.crc  = crc_q;
endmodule
`default_nettype wire

>>> rtl/core/modbus_rtu_register_slave.sv
// modbus rtu slave over a holding register file; request bytes in, response groups out
// flow: a byte from the third on passes StFeed and StWait, which waits out the bit-serial crc unit;
// a frame end is checked in StCheck and decided in StDecide, then each reply byte passes StRdAddr,
// StRdData, StByte, StByteW, crc bytes StCrcLo, StCrcHi, a StSend handshake per group of up to four
// throughput: one request byte at a time, ready is low while a byte or reply is worked
// reset: asynchronous active low; a clearing pass in StClear zeroes
// the register memory after reset, and no byte is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_register_slave import mbrtu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	mbrtu_rx_if.sink        rx,
	mbrtu_tx_if.source      tx
);
	// sequencer states
	localparam logic [3:0] StClear  = 4'd0;
	localparam logic [3:0] StIdle   = 4'd1;
	localparam logic [3:0] StFeed   = 4'd2;
	localparam logic [3:0] StWait   = 4'd3;
	localparam logic [3:0] StCheck  = 4'd4;
	localparam logic [3:0] StDecide = 4'd5;
	localparam logic [3:0] StRdAddr = 4'd6;
	localparam logic [3:0] StRdData = 4'd7;
	localparam logic [3:0] StByte   = 4'd8;
	localparam logic [3:0] StByteW  = 4'd9;
	localparam logic [3:0] StCrcLo  = 4'd10;
	localparam logic [3:0] StCrcHi  = 4'd11;
	localparam logic [3:0] StSend   = 4'd12;

	// reply kinds
	localparam logic [1:0] KindExc  = 2'd0;
	localparam logic [1:0] KindRead = 2'd1;
	localparam logic [1:0] KindEcho = 2'd2;
	localparam logic [1:0] KindNone = 2'd3;

	logic [3:0]  st_q;
	logic [7:0]  slave_addr_q;
	logic [8:0]  pos_q;
	logic        ovf_q;
	logic [7:0]  hdr_q [6];
	logic [7:0]  lag0_q, lag1_q;
	logic        last_q;
	logic [RegAw-1:0] clr_q;

	// register memory
	logic [15:0] mem [RegisterCount];
	logic [15:0] mem_rd_q;
	logic        mem_we;
	logic [RegAw-1:0] mem_wa;
	logic [15:0] mem_wd;
	logic [RegAw-1:0] mem_ra;

	// reply walk
	logic [1:0]  kind_q;      // exception, read, write echo, or none (drop / crc phase)
	logic [7:0]  exc_q;
	logic [7:0]  tlen_q;      // bytes before crc
	logic [7:0]  tidx_q;
	logic [RegAw-1:0] raddr_q;
	logic [7:0]  cur_q;
	logic [7:0]  g_q [4];
	logic [2:0]  gcnt_q;
	logic        glast_q;

	crc_cmd_t crc_cmd;
	crc_sts_t crc_sts;

	mbrtu_crc u_crc (.clk(clk), .arst_n(arst_n), .cmd(crc_cmd), .sts(crc_sts));

	// decoded header fields
	logic [15:0] fa, fb;
	logic [16:0] span;
	assign fa = {hdr_q[2], hdr_q[3]};
	assign fb = {hdr_q[4], hdr_q[5]};
	assign span = {1'b0, fa} + {1'b0, fb} - 17'd1;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slave_addr_q <= 8'd1;
		else if (cfg_we)
			slave_addr_q <= cfg_wdata;
	end

	// next response byte in wire order
	logic [7:0] next_byte;
	always_comb begin
		next_byte = 8'h00;
		case (kind_q)
			KindExc: begin
				if (tidx_q == 8'd0)
					next_byte = slave_addr_q;
				else if (tidx_q == 8'd1)
					next_byte = hdr_q[1] | 8'h80;
				else
					next_byte = exc_q;
			end
			KindRead: begin
				if (tidx_q == 8'd0)
					next_byte = slave_addr_q;
				else if (tidx_q == 8'd1)
					next_byte = hdr_q[1];
				else if (tidx_q == 8'd2)
					next_byte = {hdr_q[5][6:0], 1'b0};
				else if (tidx_q[0])
					next_byte = mem_rd_q[15:8];
				else
					next_byte = mem_rd_q[7:0];
			end
			default: next_byte = hdr_q[tidx_q[2:0] > 3'd5 ? 3'd5 : tidx_q[2:0]];
		endcase
	end

	// next register needed: the low byte (even index >= 4) ends a register
	logic need_rd;
	assign need_rd = (kind_q == KindRead) && (tidx_q >= 8'd4) && !tidx_q[0];

	assign rx.ready = (st_q == StIdle);
	assign mem_ra = raddr_q;

	always_comb begin
		crc_cmd = '0;
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = 16'h0000;
		case (st_q)
			StClear: mem_we = 1'b1;
			StIdle: begin
				// the byte two places back enters the crc as a new one arrives
				if (rx.valid && pos_q >= 9'd2 && pos_q < 9'(MaxFrameBytes)) begin
					crc_cmd.load = 1'b1;
					crc_cmd.data = lag0_q;
				end
			end
			StCheck: crc_cmd.init = 1'b0;
			StByte: begin
				crc_cmd.load = 1'b1;
				crc_cmd.data = cur_q;
			end
			StDecide: begin
				if (kind_q != KindNone && hdr_q[1] == FuncWrite &&
				    fa < 16'(RegisterCount)) begin
					mem_we = 1'b1;
					mem_wa = fa[RegAw-1:0];
					mem_wd = fb;
				end
				crc_cmd.init = 1'b1;
			end
			// reseed for the next request once the reply is gone
			StSend: if (tx.ready && glast_q) crc_cmd.init = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StClear;
			clr_q <= '0;
			pos_q <= '0;
			ovf_q <= 1'b0;
			gcnt_q <= '0;
			glast_q <= 1'b0;
			tx.valid <= 1'b0;
		end else begin
			case (st_q)
				StClear: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == RegAw'(RegisterCount - 1))
						st_q <= StIdle;
				end
				StIdle: begin
					if (rx.valid) begin
						last_q <= rx.frame_end;
						if (pos_q >= 9'(MaxFrameBytes)) begin
							ovf_q <= 1'b1;
							st_q <= rx.frame_end ? StCheck : StIdle;
						end else begin
							if (pos_q < 9'd6)
								hdr_q[pos_q[2:0]] <= rx.rx_byte;
							lag0_q <= lag1_q;
							lag1_q <= rx.rx_byte;
							pos_q <= pos_q + 9'd1;
							if (pos_q >= 9'd2)
								st_q <= StFeed;
							else
								st_q <= rx.frame_end ? StCheck : StIdle;
						end
					end
				end
				StFeed: st_q <= StWait;
				StWait: if (!crc_sts.busy) st_q <= last_q ? StCheck : StIdle;
				StCheck: begin
					if (ovf_q || pos_q < 9'd6 || hdr_q[0] != slave_addr_q ||
					    {lag1_q, lag0_q} != crc_sts.crc) begin
						pos_q <= '0;
						ovf_q <= 1'b0;
						st_q <= StDecide;
						kind_q <= KindNone;
					end else begin
						kind_q <= KindExc;
						st_q <= StDecide;
					end
				end
				StDecide: begin
					pos_q <= '0;
					ovf_q <= 1'b0;
					tidx_q <= '0;
					gcnt_q <= '0;
					raddr_q <= fa[RegAw-1:0];
					if (kind_q == KindNone) begin
						st_q <= StIdle;
					end else if (hdr_q[1] == FuncRead) begin
						if (fb == 16'd0 || fb > ReadLimit) begin
							kind_q <= KindExc; exc_q <= ExcValue; tlen_q <= 8'd3;
						end else if (span >= 17'(RegisterCount)) begin
							kind_q <= KindExc; exc_q <= ExcAddress; tlen_q <= 8'd3;
						end else begin
							kind_q <= KindRead;
							tlen_q <= 8'd3 + {hdr_q[5][6:0], 1'b0};
						end
						st_q <= StRdAddr;
					end else if (hdr_q[1] == FuncWrite) begin
						if (fa >= 16'(RegisterCount)) begin
							kind_q <= KindExc; exc_q <= ExcAddress; tlen_q <= 8'd3;
						end else begin
							kind_q <= KindEcho; tlen_q <= 8'd6;
						end
						st_q <= StRdAddr;
					end else begin
						kind_q <= KindExc; exc_q <= ExcFunction; tlen_q <= 8'd3;
						st_q <= StRdAddr;
					end
				end
				// StRdAddr lets the registered memory read settle before StRdData uses it
				StRdAddr: st_q <= StRdData;
				StRdData: begin
					if (tidx_q == tlen_q) begin
						st_q <= StCrcLo;
					end else begin
						cur_q <= next_byte;
						st_q <= StByte;
					end
				end
				StByte: begin
					g_q[gcnt_q[1:0]] <= cur_q;
					gcnt_q <= gcnt_q + 3'd1;
					tidx_q <= tidx_q + 8'd1;
					if (need_rd)
						raddr_q <= raddr_q + 1'b1;
					st_q <= StByteW;
				end
				StByteW: begin
					if (!crc_sts.busy) begin
						if (gcnt_q == 3'd4) begin
							glast_q <= 1'b0;
							tx.valid <= 1'b1;
							st_q <= StSend;
						end else
							st_q <= StRdAddr;
					end
				end
				StCrcLo: begin
					g_q[gcnt_q[1:0]] <= crc_sts.crc[7:0];
					gcnt_q <= gcnt_q + 3'd1;
					if (gcnt_q == 3'd3) begin
						glast_q <= 1'b0;
						tx.valid <= 1'b1;
						kind_q <= KindNone; // marks crc phase for resume
						st_q <= StSend;
					end else
						st_q <= StCrcHi;
				end
				StCrcHi: begin
					g_q[gcnt_q[1:0]] <= crc_sts.crc[15:8];
					gcnt_q <= gcnt_q + 3'd1;
					glast_q <= 1'b1;
					tx.valid <= 1'b1;
					st_q <= StSend;
				end
				StSend: begin
					if (tx.ready) begin
						tx.valid <= 1'b0;
						gcnt_q <= '0;
						if (glast_q)
							st_q <= StIdle;
						else if (kind_q == KindNone)
							st_q <= StCrcHi;
						else
							st_q <= StRdAddr;
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	assign tx.tx_byte_0 = (gcnt_q > 3'd0) ? g_q[0] : 8'h00;
	assign tx.tx_byte_1 = (gcnt_q > 3'd1) ? g_q[1] : 8'h00;
	assign tx.tx_byte_2 = (gcnt_q > 3'd2) ? g_q[2] : 8'h00;
	assign tx.tx_byte_3 = (gcnt_q > 3'd3) ? g_q[3] : 8'h00;
	assign tx.bytes_valid = gcnt_q;
	assign tx.last_group = glast_q;
endmodule
`default_nettype wire
